@@ rtl/synchronized_led_blink_code_driver_macros.svh @@
// ----------------------------------------------------------------------------
// synchronized_led_blink_code_driver_macros
// assertion macros shared by the led blink code driver rtl
// ----------------------------------------------------------------------------
`ifndef SYNCHRONIZED_LED_BLINK_CODE_DRIVER_MACROS_SVH
`define SYNCHRONIZED_LED_BLINK_CODE_DRIVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SLBCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slbcd assertion failed");

// next-cycle implication, checked outside reset
`define SLBCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slbcd assertion failed");

`endif

@@ rtl/slbcd_pkg.sv @@
// ----------------------------------------------------------------------------
// slbcd_pkg
// types, constants and helpers for the led blink code driver
// ----------------------------------------------------------------------------
`default_nettype none

package slbcd_pkg;

    // number of driven leds
    localparam int NUM_LEDS = 8;
    localparam int LED_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

    // fixed field widths
    localparam int MODE_W    = 2;
    localparam int IDX_IN_W  = 3;
    localparam int COUNT_W   = 8;
    localparam int LEVEL_W   = 8;
    localparam int PERIOD_W  = 6;
    localparam int TIME_W    = 8;
    localparam int STEP_W    = 8;
    localparam int PAT_W     = 18;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    // timing constants
    localparam int DUE_LIMIT  = 162;
    localparam int STEP_FIRST = 93;
    localparam int STEP_OTHER = 94;

    // flash pattern constants
    localparam int          FLASH_LIMIT = 8;
    localparam logic [31:0] FLASH_BASE  = 32'd16;
    localparam logic [31:0] FLASH_MASK  = 32'h5555_5555;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL_MASK = 1'b1;

    // input word kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_FLASH = 2'd2
    } mode_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LED  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    // flash pattern with bits 4, 6, .., 2*cnt+2 set
    function automatic logic [PAT_W-1:0] flash_bits(input logic [COUNT_W-1:0] cnt);
        logic [31:0] full;
        full = ((FLASH_BASE << {cnt[2:0], 1'b0}) - FLASH_BASE) & FLASH_MASK;
        return full[PAT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/synchronized_led_blink_code_driver.sv @@
// ----------------------------------------------------------------------------
// synchronized_led_blink_code_driver
// drives status leds in lockstep from a shared frame step counter
// ----------------------------------------------------------------------------
// sequencing: a due tick runs through S_LED, where the led update unit serves
//   one led per cycle, and then S_DONE; any other word goes straight to S_DONE
// flow: a new word is accepted only in S_IDLE, after the last one left S_DONE;
//   the output register lets the next word in while a result waits
// reset: asynchronous, clears all counts, patterns, time, deadline and pins
// ----------------------------------------------------------------------------
`default_nettype none
`include "synchronized_led_blink_code_driver_macros.svh"

module synchronized_led_blink_code_driver (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [slbcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [slbcd_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [slbcd_pkg::MODE_W-1:0]     mode,
    input  wire logic [slbcd_pkg::IDX_IN_W-1:0]   led_index,
    input  wire logic [slbcd_pkg::COUNT_W-1:0]    count,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [slbcd_pkg::LEVEL_W-1:0]         led_levels,
    output logic                                  step_taken
);

    localparam int N  = slbcd_pkg::NUM_LEDS;
    localparam int LW = slbcd_pkg::LED_W;

    // state
    slbcd_pkg::state_t                      state_reg, state_next;
    logic [LW-1:0]                          led_cnt_reg, led_cnt_next;
    logic                                   taken_reg, taken_next;
    logic [slbcd_pkg::PERIOD_W-1:0]         blink_period_reg, blink_period_next;
    logic [slbcd_pkg::LEVEL_W-1:0]          off_mask_reg, off_mask_next;
    logic [slbcd_pkg::COUNT_W-1:0]          req_reg [N], req_next [N];
    logic [slbcd_pkg::COUNT_W-1:0]          lat_reg [N], lat_next [N];
    logic [slbcd_pkg::PAT_W-1:0]            pat_reg [N], pat_next [N];
    logic [slbcd_pkg::STEP_W-1:0]           step_reg, step_next;
    logic [slbcd_pkg::TIME_W-1:0]           deadline_reg, deadline_next;
    logic [slbcd_pkg::TIME_W-1:0]           time_reg, time_next;
    logic [N-1:0]                           pin_reg, pin_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [slbcd_pkg::LEVEL_W-1:0]          out_levels_reg, out_levels_next;
    logic                                   out_taken_reg, out_taken_next;

    // datapath signals
    logic                                   accept;
    logic                                   idx_ok;
    logic [LW-1:0]                          rd_idx;
    logic [slbcd_pkg::PAT_W-1:0]            pat_rd;
    logic [slbcd_pkg::PAT_W-1:0]            pat_shift;
    logic [slbcd_pkg::COUNT_W-1:0]          n_cur;
    logic [slbcd_pkg::TIME_W-1:0]           time_inc;
    logic [slbcd_pkg::TIME_W-1:0]           elapsed;
    logic                                   due;
    logic [slbcd_pkg::STEP_W-1:0]           step_inc;
    logic [slbcd_pkg::STEP_W-1:0]           wrap_at;
    logic                                   led_on;
    logic                                   out_free;

    assign in_ready   = (state_reg == slbcd_pkg::S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign led_levels = out_levels_reg;
    assign step_taken = out_taken_reg;

    // single read port shared by request handling and the led loop
    assign idx_ok = (32'(led_index) < N);
    assign rd_idx = in_ready ? LW'(led_index) : led_cnt_reg;
    assign pat_rd = pat_reg[rd_idx];

    // tick due check
    assign time_inc = time_reg + 8'd1;
    assign elapsed  = time_inc - deadline_reg;
    assign due      = (elapsed < 8'(slbcd_pkg::DUE_LIMIT));

    // led update unit, one led per cycle
    assign n_cur     = (step_reg == '0) ? req_reg[led_cnt_reg] : lat_reg[led_cnt_reg];
    assign pat_shift = pat_rd >> 1;
    always_comb
    begin
        if (pat_rd != '0)
        begin
            led_on = pat_rd[0];
        end
        else if (n_cur > {2'b00, blink_period_reg})
        begin
            led_on = (step_reg != '0);
        end
        else if (n_cur == {2'b00, blink_period_reg})
        begin
            led_on = !step_reg[0];
        end
        else if ({n_cur, 2'b00} > {2'b00, step_reg})
        begin
            led_on = (step_reg[1:0] == 2'b00);
        end
        else
        begin
            led_on = 1'b0;
        end
    end

    // frame step advance
    assign step_inc = step_reg + 8'd1;
    assign wrap_at  = {blink_period_reg, 2'b00};

    // sequencer and next state
    always_comb
    begin
        state_next        = state_reg;
        led_cnt_next      = led_cnt_reg;
        taken_next        = taken_reg;
        blink_period_next = blink_period_reg;
        off_mask_next     = off_mask_reg;
        req_next          = req_reg;
        lat_next          = lat_reg;
        pat_next          = pat_reg;
        step_next         = step_reg;
        deadline_next     = deadline_reg;
        time_next         = time_reg;
        pin_next          = pin_reg;
        out_valid_next    = out_valid_reg;
        out_levels_next   = out_levels_reg;
        out_taken_next    = out_taken_reg;

        // configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                slbcd_pkg::REG_BLINK_PERIOD:
                    blink_period_next = cfg_data[slbcd_pkg::PERIOD_W-1:0];
                slbcd_pkg::REG_OFF_LEVEL_MASK:
                    off_mask_next = cfg_data;
                default: ;
            endcase
        end

        // result word handed off
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            slbcd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    taken_next = 1'b0;
                    state_next = slbcd_pkg::S_DONE;
                    case (mode)
                        slbcd_pkg::MODE_TICK:
                        begin
                            time_next = time_inc;
                            if (due)
                            begin
                                deadline_next = deadline_reg + ((step_reg[1:0] != 2'b00) ?
                                    8'(slbcd_pkg::STEP_OTHER) : 8'(slbcd_pkg::STEP_FIRST));
                                led_cnt_next = LW'(N - 1);
                                taken_next   = 1'b1;
                                state_next   = slbcd_pkg::S_LED;
                            end
                        end
                        slbcd_pkg::MODE_SET:
                        begin
                            if (idx_ok)
                            begin
                                req_next[rd_idx] = count;
                            end
                        end
                        slbcd_pkg::MODE_FLASH:
                        begin
                            if (idx_ok && pat_rd == '0 &&
                                count < 8'(slbcd_pkg::FLASH_LIMIT))
                            begin
                                pat_next[rd_idx] = slbcd_pkg::flash_bits(count);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            slbcd_pkg::S_LED:
            begin
                // latch, shift pattern and drive one pin
                lat_next[led_cnt_reg] = n_cur;
                if (pat_rd != '0)
                begin
                    pat_next[led_cnt_reg] = pat_shift;
                    if (pat_shift == '0)
                    begin
                        lat_next[led_cnt_reg] = '0;
                    end
                end
                pin_next[led_cnt_reg] = off_mask_reg[led_cnt_reg] ^ led_on;
                if (led_cnt_reg == '0)
                begin
                    step_next  = (wrap_at <= step_inc) ? '0 : step_inc;
                    state_next = slbcd_pkg::S_DONE;
                end
                else
                begin
                    led_cnt_next = led_cnt_reg - 1'b1;
                end
            end
            slbcd_pkg::S_DONE:
            begin
                // load the output register once it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_levels_next = slbcd_pkg::LEVEL_W'(pin_reg);
                    out_taken_next  = taken_reg;
                    state_next      = slbcd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = slbcd_pkg::S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= slbcd_pkg::S_IDLE;
            led_cnt_reg      <= '0;
            taken_reg        <= 1'b0;
            blink_period_reg <= 6'd4;
            off_mask_reg     <= '0;
            for (int i = 0; i < N; i++)
            begin
                req_reg[i] <= '0;
                lat_reg[i] <= '0;
                pat_reg[i] <= '0;
            end
            step_reg         <= '0;
            deadline_reg     <= '0;
            time_reg         <= '0;
            pin_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            led_cnt_reg      <= led_cnt_next;
            taken_reg        <= taken_next;
            blink_period_reg <= blink_period_next;
            off_mask_reg     <= off_mask_next;
            req_reg          <= req_next;
            lat_reg          <= lat_next;
            pat_reg          <= pat_next;
            step_reg         <= step_next;
            deadline_reg     <= deadline_next;
            time_reg         <= time_next;
            pin_reg          <= pin_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_levels_reg <= out_levels_next;
        out_taken_reg  <= out_taken_next;
    end

    // checks
    `SLBCD_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
    `SLBCD_ASSERT_NEXT(a_request_short, accept && (mode != slbcd_pkg::MODE_TICK),
        state_reg == slbcd_pkg::S_DONE)
    `SLBCD_ASSERT_NEXT(a_loop_ends, (state_reg == slbcd_pkg::S_LED) && (led_cnt_reg == '0),
        (state_reg == slbcd_pkg::S_DONE) && taken_reg)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the synchronized led blink code driver: a word
// level predictor of time, deadline, frame step, counts and flash patterns
// follows every accepted word and each result word is compared against it
// ----------------------------------------------------------------------------

module tb_top;

    localparam logic [slbcd_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 10;
    localparam int TAIL_CYCLES = 20;
    localparam int EVENTS_PER_PHASE = 50;
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic [slbcd_pkg::LEVEL_W-1:0] levels;
        logic                          taken;
    } pin_report_t;

    // block ports
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [slbcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [slbcd_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [slbcd_pkg::MODE_W-1:0]    mode = '0;
    logic [slbcd_pkg::IDX_IN_W-1:0]  led_index = '0;
    logic [slbcd_pkg::COUNT_W-1:0]   count = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [slbcd_pkg::LEVEL_W-1:0]   led_levels;
    logic                            step_taken;

    // predicted block state
    logic [slbcd_pkg::PERIOD_W-1:0]  model_period;
    logic [slbcd_pkg::LEVEL_W-1:0]   model_off_mask;
    logic [slbcd_pkg::COUNT_W-1:0]   wanted_count [slbcd_pkg::NUM_LEDS];
    logic [slbcd_pkg::COUNT_W-1:0]   held_count [slbcd_pkg::NUM_LEDS];
    logic [slbcd_pkg::PAT_W-1:0]     flash_shift [slbcd_pkg::NUM_LEDS];
    logic [slbcd_pkg::STEP_W-1:0]    step_now;
    logic [slbcd_pkg::TIME_W-1:0]    deadline_now;
    logic [slbcd_pkg::TIME_W-1:0]    clock_ms;
    logic [slbcd_pkg::LEVEL_W-1:0]   pins_now;

    // expected result words, oldest first
    pin_report_t pin_reports [$];

    int mismatches = 0;
    bit quiet = 1'b0;
    bit valid_up = 1'b0;
    int stall_left = 0;

    always #(HALF_PERIOD) clk = ~clk;

    synchronized_led_blink_code_driver u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .led_index  (led_index),
        .count      (count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .led_levels (led_levels),
        .step_taken (step_taken)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(99));
        if (r < 60)
            return 0;
        else if (r < 90)
            return int'($urandom_range(3, 1));
        else if (r < 97)
            return int'($urandom_range(10, 4));
        else
            return int'($urandom_range(40, 11));
    endfunction

    // blink counts clustered around the current period
    function automatic logic [slbcd_pkg::COUNT_W-1:0] pick_count();
        int r;
        int c;
        r = int'($urandom_range(99));
        if (r < 30)
            c = int'(model_period) + int'($urandom_range(2)) - 1;
        else if (r < 70)
            c = int'($urandom_range(int'(model_period)));
        else
            c = int'($urandom_range(255));
        return c[slbcd_pkg::COUNT_W-1:0];
    endfunction

    function automatic void clear_model();
        model_period = 6'd4;
        model_off_mask = '0;
        for (int i = 0; i < slbcd_pkg::NUM_LEDS; i++)
        begin
            wanted_count[i] = '0;
            held_count[i] = '0;
            flash_shift[i] = '0;
        end
        step_now = '0;
        deadline_now = '0;
        clock_ms = '0;
        pins_now = '0;
    endfunction

    function automatic void set_pin(int i, bit on);
        pins_now[i] = model_off_mask[i] ^ on;
    endfunction

    // one frame step of one led
    function automatic void refresh_led(int i, int s);
        int n;
        int p;
        if (s == 0)
            held_count[i] = wanted_count[i];
        n = int'(held_count[i]);
        p = int'(model_period);
        if (flash_shift[i] != '0)
        begin
            set_pin(i, flash_shift[i][0]);
            flash_shift[i] = flash_shift[i] >> 1;
            if (flash_shift[i] == '0)
                held_count[i] = '0;
        end
        else if (n > p)
            set_pin(i, s != 0);
        else if (n == p)
            set_pin(i, (s % 2) == 0);
        else if (4 * n > s)
            set_pin(i, (s % 4) == 0);
        else
            set_pin(i, 1'b0);
    endfunction

    // apply one accepted word to the predicted state
    function automatic pin_report_t predict_word(
        input logic [slbcd_pkg::MODE_W-1:0]   m,
        input logic [slbcd_pkg::IDX_IN_W-1:0] idx,
        input logic [slbcd_pkg::COUNT_W-1:0]  cnt);
        pin_report_t rep;
        logic [slbcd_pkg::TIME_W-1:0] lag;
        rep.taken = 1'b0;
        if (m == slbcd_pkg::MODE_TICK)
        begin
            clock_ms = clock_ms + 1'b1;
            lag = clock_ms - deadline_now;
            if (lag < slbcd_pkg::DUE_LIMIT)
            begin
                deadline_now = deadline_now + ((step_now[1:0] != 2'd0) ?
                    8'(slbcd_pkg::STEP_OTHER) : 8'(slbcd_pkg::STEP_FIRST));
                for (int i = slbcd_pkg::NUM_LEDS - 1; i >= 0; i--)
                    refresh_led(i, int'(step_now));
                step_now = step_now + 1'b1;
                if (4 * int'(model_period) <= int'(step_now))
                    step_now = '0;
                rep.taken = 1'b1;
            end
        end
        else if (m == slbcd_pkg::MODE_SET)
        begin
            if (idx < slbcd_pkg::NUM_LEDS)
                wanted_count[idx] = cnt;
        end
        else if (m == slbcd_pkg::MODE_FLASH)
        begin
            // bits 4, 6, .. set, one per flash; refused while a pattern runs
            if (idx < slbcd_pkg::NUM_LEDS && flash_shift[idx] == '0 &&
                cnt < slbcd_pkg::FLASH_LIMIT)
                for (int k = 0; k < cnt; k++)
                    flash_shift[idx][4 + 2 * k] = 1'b1;
        end
        rep.levels = pins_now;
        return rep;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want,
                                          logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0h actual %0h at %0t ns",
                     what, want, got, $time);
    endfunction

    // send one word and record its predicted result
    task automatic send_word(input logic [slbcd_pkg::MODE_W-1:0] m,
                             input logic [slbcd_pkg::IDX_IN_W-1:0] idx,
                             input logic [slbcd_pkg::COUNT_W-1:0] cnt,
                             output logic stepped);
        int gap;
        pin_report_t rep;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            if (valid_up)
                in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        valid_up = 1'b1;
        mode <= m;
        led_index <= idx;
        count <= cnt;
        do @(posedge clk); while (!in_ready);
        rep = predict_word(m, idx, cnt);
        pin_reports.push_back(rep);
        stepped = rep.taken;
    endtask

    // ticks until one of them advances the frame step
    task automatic run_to_step();
        logic stepped;
        do
            send_word(slbcd_pkg::MODE_TICK, 3'($urandom_range(7)),
                      8'($urandom_range(255)), stepped);
        while (!stepped);
    endtask

    task automatic drain_results();
        if (valid_up)
            in_valid <= 1'b0;
        valid_up = 1'b0;
        do @(posedge clk); while (pin_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [slbcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [slbcd_pkg::CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == slbcd_pkg::REG_BLINK_PERIOD)
            model_period = data[slbcd_pkg::PERIOD_W-1:0];
        else
            model_off_mask = data;
    endtask

    // both registers, written once the block has gone idle
    task automatic set_config(input logic [slbcd_pkg::PERIOD_W-1:0] period,
                              input logic [slbcd_pkg::LEVEL_W-1:0] mask);
        logic [slbcd_pkg::CFG_W-1:0] junk;
        junk = 8'($urandom_range(255));
        drain_results();
        write_reg(slbcd_pkg::REG_BLINK_PERIOD,
                  {junk[slbcd_pkg::CFG_W-1:slbcd_pkg::PERIOD_W], period});
        write_reg(slbcd_pkg::REG_OFF_LEVEL_MASK, mask);
    endtask

    // levels are off after reset and the very first tick is due
    task automatic test_reset_state();
        logic stepped;
        send_word(MODE_UNUSED, 3'($urandom_range(7)), 8'($urandom_range(255)), stepped);
        run_to_step();
    endtask

    // counts of zero, below, equal to and above the period, and the maximum
    task automatic test_blink_counts();
        logic stepped;
        set_config(6'd2, 8'h00);
        send_word(slbcd_pkg::MODE_SET, 3'd0, 8'd0, stepped);
        send_word(slbcd_pkg::MODE_SET, 3'd1, 8'd255, stepped);
        send_word(slbcd_pkg::MODE_SET, 3'd2, 8'd2, stepped);
        send_word(slbcd_pkg::MODE_SET, 3'd3, 8'd1, stepped);
        send_word(slbcd_pkg::MODE_SET, 3'd4, 8'd3, stepped);
        send_word(slbcd_pkg::MODE_SET, 3'd5, 8'd1, stepped);
        send_word(slbcd_pkg::MODE_SET, 3'd6, 8'd2, stepped);
        send_word(slbcd_pkg::MODE_SET, 3'd7, 8'd0, stepped);
        repeat (4) run_to_step();
    endtask

    // flash patterns, empty and oversized requests, request while busy
    task automatic test_flash_requests();
        logic stepped;
        send_word(slbcd_pkg::MODE_FLASH, 3'd7, 8'd1, stepped);
        send_word(slbcd_pkg::MODE_FLASH, 3'd6, 8'd7, stepped);
        send_word(slbcd_pkg::MODE_FLASH, 3'd5, 8'd0, stepped);
        send_word(slbcd_pkg::MODE_FLASH, 3'd4, 8'd8, stepped);
        send_word(slbcd_pkg::MODE_FLASH, 3'd3, 8'd255, stepped);
        send_word(slbcd_pkg::MODE_FLASH, 3'd7, 8'd3, stepped);
        repeat (5) run_to_step();
    endtask

    // zero and full period, inverted polarity, mask change before a step
    task automatic test_config_extremes();
        logic stepped;
        set_config(6'd0, 8'hFF);
        run_to_step();
        set_config(6'd63, 8'h5A);
        send_word(MODE_UNUSED, 3'($urandom_range(7)), 8'($urandom_range(255)), stepped);
        run_to_step();
    endtask

    task automatic random_event();
        int r;
        logic stepped;
        logic [slbcd_pkg::COUNT_W-1:0] cnt;
        r = int'($urandom_range(99));
        if (r < 40)
            send_word(slbcd_pkg::MODE_TICK, 3'($urandom_range(7)),
                      8'($urandom_range(255)), stepped);
        else if (r < 65)
            send_word(slbcd_pkg::MODE_SET, 3'($urandom_range(7)), pick_count(), stepped);
        else if (r < 90)
        begin
            cnt = ($urandom_range(9) < 8) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
            send_word(slbcd_pkg::MODE_FLASH, 3'($urandom_range(7)), cnt, stepped);
        end
        else
            send_word(MODE_UNUSED, 3'($urandom_range(7)), 8'($urandom_range(255)), stepped);
    endtask

    // phases of mixed traffic under different periods and masks
    task automatic test_random_traffic();
        logic [slbcd_pkg::PERIOD_W-1:0] period;
        logic [slbcd_pkg::LEVEL_W-1:0] mask;
        for (int ph = 0; ph < 2; ph++)
        begin
            if (ph == 0)
                period = 6'd1;
            else
                period = 6'($urandom_range(63));
            mask = 8'($urandom_range(255));
            set_config(period, mask);
            for (int e = 0; e < EVENTS_PER_PHASE; e++)
            begin
                if (e % 25 == 0)
                    quiet = ($urandom_range(3) == 0);
                random_event();
            end
        end
        quiet = 1'b0;
    endtask

    // result side backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(99) < 20)
        begin
            stall_left = pick_gap();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        pin_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pin_reports.size() == 0)
                note_mismatch("unexpected word", 32'd0, 32'({led_levels, step_taken}));
            else
            begin
                want = pin_reports.pop_front();
                if (led_levels !== want.levels)
                    note_mismatch("led_levels", 32'(want.levels), 32'(led_levels));
                if (step_taken !== want.taken)
                    note_mismatch("step_taken", 32'(want.taken), 32'(step_taken));
            end
        end
    end

    initial
    begin
        clear_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_blink_counts();
        test_flash_requests();
        test_config_extremes();
        test_random_traffic();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pin_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hang guard
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
